// ----- rtl/upsc_pkg.sv -----
// shared types, constants and register codes for the proximity stepper block
`default_nettype none

package upsc_pkg;

   localparam int unsigned COUNT_W  = 16;
   localparam int unsigned DIST_W   = 10;
   localparam int unsigned THRESH_W = 10;
   localparam int unsigned RUN_W    = 24;
   localparam int unsigned MS_CFG_W = 10;
   localparam int unsigned TIME_W   = 32;
   localparam int unsigned COIL_W   = 4;
   localparam int unsigned PHASE_W  = 2;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 24;

   // divide by 116 as multiply by ceil(2^22 / 116), exact for all 16-bit counts
   localparam logic [COUNT_W-1:0] CM_RECIP       = 16'd36158;
   localparam int unsigned        CM_RECIP_SHIFT = 22;

   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RUN_TIME  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_PER  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MEAS_INT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ECHO_TO   = 3'd4;

   localparam logic [THRESH_W-1:0] THRESHOLD_RST = 10'd10;
   localparam logic [RUN_W-1:0]    RUN_TIME_RST  = 24'd30000;
   localparam logic [MS_CFG_W-1:0] STEP_PER_RST  = 10'd10;
   localparam logic [MS_CFG_W-1:0] MEAS_INT_RST  = 10'd60;
   localparam logic [MS_CFG_W-1:0] ECHO_TO_RST   = 10'd30;

   localparam logic [COIL_W-1:0] COIL_FIRST = 4'b1000;

   typedef struct packed {
      logic [THRESH_W-1:0] threshold_cm;
      logic [RUN_W-1:0]    run_time_ms;
      logic [MS_CFG_W-1:0] step_period_ms;
      logic [MS_CFG_W-1:0] measure_interval_ms;
      logic [MS_CFG_W-1:0] echo_timeout_ms;
   } cfg_type;

   typedef enum logic [2:0] {
      MODE_IDLE      = 3'b001,
      MODE_WAIT_HIGH = 3'b010,
      MODE_MEASURE   = 3'b100
   } ranger_mode_type;

   typedef struct packed {
      logic              fire;
      logic              updated;
      logic [DIST_W-1:0] distance;
   } ranger_out_type;

   typedef struct packed {
      logic [COIL_W-1:0] coil;
      logic              running;
      logic              started;
      logic              finished;
   } stepper_out_type;

endpackage

`default_nettype wire

// ----- rtl/upsc_ranger.sv -----
// echo ranger: trigger scheduling, echo timing and distance conversion
`default_nettype none

module upsc_ranger (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           step,
   input  wire                           echo_level,
   input  wire  [upsc_pkg::COUNT_W-1:0]  timer_count,
   input  wire  [upsc_pkg::TIME_W-1:0]   now_ms,
   input  upsc_pkg::cfg_type             cfg,
   output upsc_pkg::ranger_out_type      result
);
   import upsc_pkg::*;

   ranger_mode_type     mode_ff, mode_in;
   logic [TIME_W-1:0]   last_start_ff, last_start_in;
   logic [TIME_W-1:0]   trigger_ff, trigger_in;
   logic [COUNT_W-1:0]  rise_ff, rise_in;
   logic [DIST_W-1:0]   distance_ff, distance_in;
   logic [COUNT_W-1:0]  dur;
   logic [2*COUNT_W-1:0] product;
   logic                timed_out;
   logic                interval_done;

   assign dur           = timer_count - rise_ff;
   assign product       = dur * CM_RECIP;
   assign timed_out     = (now_ms - trigger_ff) >= TIME_W'(cfg.echo_timeout_ms);
   assign interval_done = (now_ms - last_start_ff) >= TIME_W'(cfg.measure_interval_ms);

   always_comb begin
      mode_in        = mode_ff;
      last_start_in  = last_start_ff;
      trigger_in     = trigger_ff;
      rise_in        = rise_ff;
      distance_in    = distance_ff;
      result.fire    = 1'b0;
      result.updated = 1'b0;
      case (mode_ff)
         MODE_WAIT_HIGH: begin
            if (echo_level) begin
               rise_in = timer_count;
               mode_in = MODE_MEASURE;
            end else if (timed_out) begin
               distance_in    = '0;
               result.updated = 1'b1;
               mode_in        = MODE_IDLE;
            end
         end
         MODE_MEASURE: begin
            if (!echo_level) begin
               distance_in    = product[CM_RECIP_SHIFT +: DIST_W];
               result.updated = 1'b1;
               mode_in        = MODE_IDLE;
            end else if (timed_out) begin
               distance_in    = '0;
               result.updated = 1'b1;
               mode_in        = MODE_IDLE;
            end
         end
         default: begin
            mode_in = MODE_IDLE;
            if (interval_done) begin
               last_start_in = now_ms;
               trigger_in    = now_ms;
               result.fire   = 1'b1;
               mode_in       = MODE_WAIT_HIGH;
            end
         end
      endcase
      result.distance = distance_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         last_start_ff <= '0;
         trigger_ff    <= '0;
         rise_ff       <= '0;
         distance_ff   <= '0;
      end else if (step) begin
         mode_ff       <= mode_in;
         last_start_ff <= last_start_in;
         trigger_ff    <= trigger_in;
         rise_ff       <= rise_in;
         distance_ff   <= distance_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/upsc_stepper.sv -----
// run control and single-coil stepper phase sequencing
`default_nettype none

module upsc_stepper (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          step,
   input  wire  [upsc_pkg::DIST_W-1:0]  distance,
   input  wire  [upsc_pkg::TIME_W-1:0]  now_ms,
   input  upsc_pkg::cfg_type            cfg,
   output upsc_pkg::stepper_out_type    result
);
   import upsc_pkg::*;

   logic                active_ff, active_in;
   logic [PHASE_W-1:0]  phase_ff, phase_in;
   logic [TIME_W-1:0]   run_start_ff, run_start_in;
   logic [TIME_W-1:0]   last_step_ff, last_step_in;
   logic [COIL_W-1:0]   coil_ff, coil_in;
   logic                start;
   logic                active_mid;
   logic [PHASE_W-1:0]  phase_mid;
   logic [TIME_W-1:0]   run_start_mid;
   logic [TIME_W-1:0]   last_step_mid;

   assign start = (distance != '0) && (distance <= cfg.threshold_cm) && !active_ff;

   // a start reloads the run timers before the stepper looks at them
   assign active_mid    = active_ff | start;
   assign phase_mid     = start ? '0 : phase_ff;
   assign run_start_mid = start ? now_ms : run_start_ff;
   assign last_step_mid = start ? now_ms : last_step_ff;

   always_comb begin
      active_in       = active_mid;
      phase_in        = phase_mid;
      run_start_in    = run_start_mid;
      last_step_in    = last_step_mid;
      coil_in         = coil_ff;
      result.finished = 1'b0;
      if (active_mid) begin
         if ((now_ms - run_start_mid) >= TIME_W'(cfg.run_time_ms)) begin
            coil_in         = '0;
            active_in       = 1'b0;
            result.finished = 1'b1;
         end else if ((now_ms - last_step_mid) >= TIME_W'(cfg.step_period_ms)) begin
            last_step_in = now_ms;
            coil_in      = COIL_FIRST >> phase_mid;
            phase_in     = phase_mid + PHASE_W'(1);
         end
      end
      result.coil    = coil_in;
      result.running = active_in;
      result.started = start;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         phase_ff     <= '0;
         run_start_ff <= '0;
         last_step_ff <= '0;
         coil_ff      <= '0;
      end else if (step) begin
         active_ff    <= active_in;
         phase_ff     <= phase_in;
         run_start_ff <= run_start_in;
         last_step_ff <= last_step_in;
         coil_ff      <= coil_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/ultrasonic_proximity_stepper_control.sv -----
// top level: input register, millisecond clock, csr bank, ranger, stepper, result register
// an accepted item passes through the input register and then the result register
// throughput: one item per cycle without rsp_stall; ranger and stepper finish in one pass
// req_stall rises only while the input register is full and the result register is held
// reset: synchronous, active high; clears control state, restores register defaults
`default_nettype none

module ultrasonic_proximity_stepper_control (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_stall,
   input  wire                              req_echo_level,
   input  wire  [upsc_pkg::COUNT_W-1:0]     req_timer_count,
   input  wire                              req_ms_tick,
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output logic                             rsp_trigger_fire,
   output logic [upsc_pkg::DIST_W-1:0]      rsp_distance_cm,
   output logic                             rsp_distance_updated,
   output logic [upsc_pkg::COIL_W-1:0]      rsp_coil_drive,
   output logic                             rsp_motor_running,
   output logic                             rsp_run_started,
   output logic                             rsp_run_finished,
   input  wire                              csr_wr_en,
   input  wire  [upsc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire  [upsc_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import upsc_pkg::*;

   logic                stg_valid_ff;
   logic                stg_echo_ff;
   logic [COUNT_W-1:0]  stg_count_ff;
   logic                stg_tick_ff;
   logic                out_valid_ff;
   logic [TIME_W-1:0]   now_ff, now_in;
   cfg_type             cfg_ff;
   logic                advance;
   logic                accept;
   ranger_out_type      rng;
   stepper_out_type     stp;

   assign advance   = stg_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = stg_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign now_in    = now_ff + TIME_W'(stg_tick_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold_cm        <= THRESHOLD_RST;
         cfg_ff.run_time_ms         <= RUN_TIME_RST;
         cfg_ff.step_period_ms      <= STEP_PER_RST;
         cfg_ff.measure_interval_ms <= MEAS_INT_RST;
         cfg_ff.echo_timeout_ms     <= ECHO_TO_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_THRESHOLD: cfg_ff.threshold_cm        <= csr_wdata[THRESH_W-1:0];
            CSR_RUN_TIME:  cfg_ff.run_time_ms         <= csr_wdata[RUN_W-1:0];
            CSR_STEP_PER:  cfg_ff.step_period_ms      <= csr_wdata[MS_CFG_W-1:0];
            CSR_MEAS_INT:  cfg_ff.measure_interval_ms <= csr_wdata[MS_CFG_W-1:0];
            CSR_ECHO_TO:   cfg_ff.echo_timeout_ms     <= csr_wdata[MS_CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
      end else if (accept) begin
         stg_valid_ff <= 1'b1;
      end else if (advance) begin
         stg_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stg_echo_ff  <= req_echo_level;
         stg_count_ff <= req_timer_count;
         stg_tick_ff  <= req_ms_tick;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff <= '0;
      end else if (advance) begin
         now_ff <= now_in;
      end
   end

   upsc_ranger u_ranger (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .echo_level  (stg_echo_ff),
      .timer_count (stg_count_ff),
      .now_ms      (now_in),
      .cfg         (cfg_ff),
      .result      (rng)
   );

   upsc_stepper u_stepper (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .distance (rng.distance),
      .now_ms   (now_in),
      .cfg      (cfg_ff),
      .result   (stp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_trigger_fire     <= rng.fire;
         rsp_distance_cm      <= rng.distance;
         rsp_distance_updated <= rng.updated;
         rsp_coil_drive       <= stp.coil;
         rsp_motor_running    <= stp.running;
         rsp_run_started      <= stp.started;
         rsp_run_finished     <= stp.finished;
      end
   end

   assign rsp_valid = out_valid_ff;

   // coils are off whenever no run is active
   a_coils_off_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_motor_running |-> rsp_coil_drive == '0)
      else $error("coils driven with no active run");

   a_single_coil: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0(rsp_coil_drive))
      else $error("more than one coil driven");

   // a trigger comes only from idle, a distance update never does
   a_fire_excludes_update: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_trigger_fire && rsp_distance_updated))
      else $error("trigger and distance update in the same item");

   a_finish_stops_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_run_finished |-> !rsp_motor_running)
      else $error("run still active after finishing");

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> stg_valid_ff && out_valid_ff && rsp_stall)
      else $error("input stalled without a held item");

endmodule

`default_nettype wire
